@@ rtl/core/ils_pkg.sv @@
package ils_pkg;

  // number of list positions, one cell each
  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 8;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  // width that holds both an index and a count for compares
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_FRONT  = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        rd_pos;
  } cell_ctrl_t;

endpackage

@@ rtl/core/ils_if.sv @@
// request channel: one list operation per item
interface ils_req_if import ils_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

// response channel: one result item per request
interface ils_rsp_if import ils_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic                    hit;
  logic                    full_drop;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output read_value, output hit, output full_drop,
                  output count, input ready);
  modport sink   (input valid, input read_value, input hit, input full_drop,
                  input count, output ready);
endinterface

@@ rtl/core/ils_cell.sv @@
module ils_cell import ils_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [POS_W-1:0]        my_pos,
  input  logic signed [VAL_W-1:0] lower,
  input  logic signed [VAL_W-1:0] upper,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] tap
);

  // insert: cells above pos take the lower neighbor, pos loads the value
  // delete: cells at or above pos take the upper neighbor
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (my_pos > ctrl.pos) begin
        data <= lower;
      end else if (my_pos == ctrl.pos) begin
        data <= ctrl.value;
      end
    end else if (ctrl.del) begin
      if (my_pos >= ctrl.pos) begin
        data <= upper;
      end
    end
  end

  // read tap, zero unless this cell is addressed
  assign tap = (my_pos == ctrl.rd_pos) ? data : '0;

endmodule

@@ rtl/core/indexed_list_store.sv @@
// indexed_list_store: ordered list of up to CAPACITY signed 32-bit values.
// req carries op, index and value; rsp returns read_value, hit, full_drop
// and the element count after the operation, one result item per request.
// Ops: read at index, insert front, append, insert before index (index equal
// to count appends), delete at index. A read past the count gives -1 with
// hit low; out-of-range inserts and deletes change nothing; an insert into a
// full list is dropped with full_drop high.
// Storage is a row of cells, one per position; an insert shifts every cell past
// the position and a delete every cell at or past it, by one neighbor in the same cycle.
// Latency: the result item is valid the cycle after the request is taken.
// Throughput: one item per cycle; the single output register lets a new
// request in whenever rsp is empty or being taken in that cycle.
// When the receiver stalls, the result holds and req.ready drops until it
// is taken. Reset (rst, synchronous) empties the list, clears rsp.valid and
// holds req.ready low; cell contents are not cleared, positions at or past
// the count are unused.
module indexed_list_store import ils_pkg::*; (
  input  logic clk,
  input  logic rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        count_next;
  cell_ctrl_t              ctrl;
  logic                    accept;
  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic signed [VAL_W-1:0] cell_tap  [CAPACITY];
  logic signed [VAL_W-1:0] rd_bus;
  logic [CMP_W-1:0]        idx_x;
  logic [CMP_W-1:0]        cnt_x;
  logic [CMP_W-1:0]        pos_x;
  logic                    in_range;
  logic                    pos_ok;
  logic                    full;
  logic                    is_ins;
  logic signed [VAL_W-1:0] rd_next;
  logic                    hit_next;
  logic                    drop_next;

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // range checks on the request
  assign idx_x    = CMP_W'(req.index);
  assign cnt_x    = CMP_W'(count_q);
  assign in_range = idx_x < cnt_x;
  assign full     = (count_q == CNT_W'(CAPACITY));

  // collect the addressed cell onto the read bus
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | cell_tap[k];
    end
  end

  // decode the op into cell control and the result
  always_comb begin
    is_ins    = 1'b0;
    pos_x     = '0;
    rd_next   = '0;
    hit_next  = 1'b0;
    ctrl.del  = 1'b0;
    case (op_t'(req.op))
      OP_READ: begin
        hit_next = in_range;
        rd_next  = in_range ? rd_bus : -32'sd1;
      end
      OP_FRONT: begin
        is_ins = 1'b1;
        pos_x  = '0;
      end
      OP_APPEND: begin
        is_ins = 1'b1;
        pos_x  = cnt_x;
      end
      OP_INSERT: begin
        is_ins = 1'b1;
        pos_x  = idx_x;
      end
      OP_DELETE: begin
        hit_next = in_range;
        ctrl.del = accept && in_range;
      end
      default: begin
      end
    endcase
    pos_ok      = is_ins && (pos_x <= cnt_x);
    drop_next   = pos_ok && full;
    ctrl.ins    = accept && pos_ok && !full;
    ctrl.pos    = ctrl.del ? POS_W'(req.index) : POS_W'(pos_x);
    ctrl.value  = req.value;
    ctrl.rd_pos = POS_W'(req.index);

    count_next = count_q;
    if (ctrl.ins) begin
      count_next = count_q + 1'b1;
    end else if (ctrl.del) begin
      count_next = count_q - 1'b1;
    end
  end

  // row of cells, each fed by both neighbors
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VAL_W-1:0] lower;
    logic signed [VAL_W-1:0] upper;
    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[k+1];
    end
    ils_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .my_pos (POS_W'(k)),
      .lower  (lower),
      .upper  (upper),
      .data   (cell_data[k]),
      .tap    (cell_tap[k])
    );
  end

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
    end else begin
      count_q <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= rd_next;
      rsp.hit        <= hit_next;
      rsp.full_drop  <= drop_next;
      rsp.count      <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a read leaves the count unchanged
  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_READ) |=> count_q == $past(count_q))
    else $error("read changed count");

  // an insert that goes through grows the count by one
  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow count");

  // a dropped insert only happens on a full list
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.full_drop |-> rsp.count == CNT_W'(CAPACITY))
    else $error("drop reported on a list that is not full");

  // insert and delete never fire together
  a_ins_del: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete at once");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench import ils_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_GAP        = 4;
  localparam int LONG_HOLD      = 60;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 26;

  // op codes the block treats as no operation
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    hit;
    logic                    full_drop;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    int unsigned             reps;
    logic                    typed_exp;
    list_result_t            want;
  } stim_row_t;

  localparam list_result_t NO_EXP = '0;

  logic clk;
  logic rst;

  ils_req_if req_ch ();
  ils_rsp_if rsp_ch ();

  indexed_list_store dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the list and its results still owed by the block
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_count;
  list_result_t            pending_results [$];

  int mismatch_count    = 0;
  int idle_cycles       = 0;
  bit burst_mode        = 1'b0;
  bit long_hold_pending = 1'b0;

  // directed items: edges of the index and value ranges, full and empty list
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_READ,    8'd0,   32'sd0,          1,  1'b1, '{-32'sd1, 1'b0, 1'b0, 7'd0}},
    '{OP_DELETE,  8'd0,   32'sd0,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd0}},
    '{OP_INSERT,  8'd1,   32'sd5,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd0}},
    '{OP_READ,    8'd255, 32'sd0,          1,  1'b1, '{-32'sd1, 1'b0, 1'b0, 7'd0}},
    '{OP_APPEND,  8'd0,   32'sh7fffffff,   1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd1}},
    '{OP_FRONT,   8'd0,   32'sh80000000,   1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd2}},
    '{OP_INSERT,  8'd2,   -32'sd1,         1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd3}},
    '{OP_INSERT,  8'd1,   32'sh5a5a5a5a,   1,  1'b0, NO_EXP},
    '{OP_READ,    8'd0,   32'sd0,          1,  1'b1, '{32'sh80000000, 1'b1, 1'b0, 7'd4}},
    '{OP_READ,    8'd3,   32'sd0,          1,  1'b0, NO_EXP},
    '{OP_SPARE_A, 8'd255, -32'sd1,         1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd4}},
    '{OP_SPARE_B, 8'd0,   32'sd7,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd4}},
    '{OP_SPARE_C, 8'd1,   32'sd9,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd4}},
    '{OP_DELETE,  8'd255, 32'sd0,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd4}},
    '{OP_DELETE,  8'd3,   32'sd0,          1,  1'b0, NO_EXP},
    '{OP_DELETE,  8'd0,   32'sd0,          1,  1'b0, NO_EXP},
    '{OP_APPEND,  8'd0,   32'sh1000,       62, 1'b0, NO_EXP},
    '{OP_FRONT,   8'd0,   32'sh0000dead,   1,  1'b1, '{32'sd0,  1'b0, 1'b1, 7'd64}},
    '{OP_APPEND,  8'd0,   32'sh0000beef,   1,  1'b1, '{32'sd0,  1'b0, 1'b1, 7'd64}},
    '{OP_INSERT,  8'd64,  32'sd1,          1,  1'b1, '{32'sd0,  1'b0, 1'b1, 7'd64}},
    '{OP_INSERT,  8'd65,  32'sd1,          1,  1'b1, '{32'sd0,  1'b0, 1'b0, 7'd64}},
    '{OP_READ,    8'd63,  32'sd0,          1,  1'b0, NO_EXP},
    '{OP_READ,    8'd64,  32'sd0,          1,  1'b1, '{-32'sd1, 1'b0, 1'b0, 7'd64}},
    '{OP_DELETE,  8'd63,  32'sd0,          1,  1'b0, NO_EXP},
    '{OP_INSERT,  8'd0,   32'sh13572468,   1,  1'b0, NO_EXP},
    '{OP_DELETE,  8'd0,   32'sd0,          64, 1'b0, NO_EXP}
  };

  // insert before pos; returns 1 when dropped because the list is full
  function automatic bit place_value(int pos, logic signed [VAL_W-1:0] value);
    if (pos > shadow_count)
      return 1'b0;
    if (shadow_count >= CAPACITY)
      return 1'b1;
    for (int k = shadow_count; k > pos; k--)
      shadow_list[k] = shadow_list[k-1];
    shadow_list[pos] = value;
    shadow_count++;
    return 1'b0;
  endfunction

  // apply one operation to the shadow list and return its result item
  function automatic list_result_t list_effect(logic [OP_W-1:0] op,
                                               logic [IDX_W-1:0] index,
                                               logic signed [VAL_W-1:0] value);
    list_result_t res;
    res = '0;
    case (op)
      OP_READ: begin
        if (index < shadow_count) begin
          res.read_value = shadow_list[index];
          res.hit        = 1'b1;
        end else begin
          res.read_value = -1;
        end
      end
      OP_FRONT:  res.full_drop = place_value(0, value);
      OP_APPEND: res.full_drop = place_value(shadow_count, value);
      OP_INSERT: res.full_drop = place_value(index, value);
      OP_DELETE: begin
        if (index < shadow_count) begin
          for (int k = index; k + 1 < shadow_count; k++)
            shadow_list[k] = shadow_list[k+1];
          shadow_count--;
          res.hit = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // offer one item, hold it until taken, then record what it should return
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] index,
                           logic signed [VAL_W-1:0] value, bit use_typed,
                           list_result_t typed_want);
    int           gap;
    list_result_t predicted;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.index <= index;
    req_ch.value <= value;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = list_effect(op, index, value);
    pending_results.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic release_req();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random item, biased to grow or shrink the list, with some raw noise
  task automatic pick_item(bit grow, output logic [OP_W-1:0] op,
                           output logic [IDX_W-1:0] index,
                           output logic signed [VAL_W-1:0] value);
    int roll;
    int mix;
    roll = $urandom_range(0, 99);
    mix  = $urandom_range(0, 99);
    if (roll < 12) begin
      op    = OP_W'($urandom_range(0, (1 << OP_W) - 1));
      index = IDX_W'($urandom);
    end else begin
      if (mix < (grow ? 65 : 10)) begin
        case ($urandom_range(0, 2))
          0:       op = OP_FRONT;
          1:       op = OP_APPEND;
          default: op = OP_INSERT;
        endcase
        index = IDX_W'($urandom_range(0, shadow_count));
      end else begin
        op = (mix < (grow ? 80 : 65)) ? OP_DELETE : OP_READ;
        if (shadow_count == 0 || $urandom_range(0, 9) == 0)
          index = IDX_W'(shadow_count);
        else
          index = IDX_W'($urandom_range(0, shadow_count - 1));
      end
    end
    case ($urandom_range(0, 15))
      0:       value = 32'sh80000000;
      1:       value = 32'sh7fffffff;
      default: value = $urandom;
    endcase
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus: reset, directed table, then grow and shrink phases
  initial begin : stimulus
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_READ;
    req_ch.index = '0;
    req_ch.value = '0;
    shadow_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_item(directed_rows[r].op, directed_rows[r].index,
                  directed_rows[r].value + k, directed_rows[r].typed_exp,
                  directed_rows[r].want);
    end
    release_req();
    wait_results_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      burst_mode = (ph % 4 == 2);
      // receiver stalls a long while so the input backs up
      if (ph == 2)
        long_hold_pending = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_item(ph % 2 == 0, op, index, value);
        send_item(op, index, value, 1'b0, NO_EXP);
      end
      release_req();
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, compare each item with the oldest expectation
  initial begin : result_checker
    int           stall;
    list_result_t want;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (long_hold_pending) begin
        stall             = LONG_HOLD;
        long_hold_pending = 1'b0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("hit", want.hit, rsp_ch.hit);
        check_field("full_drop", want.full_drop, rsp_ch.full_drop);
        check_field("count", want.count, rsp_ch.count);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
